/* sv/sha2_pkg.sv */
// SHA-256/224 engine package: round constants, initial values, shared types.
// Depends on nothing; used by every other file of the engine but sha2_if.
package sha2_pkg;

	localparam int RoundCount = 64;
	localparam int FifoDepth  = 2;

	typedef enum logic {
		CMD_ABSORB = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_t;

	typedef enum logic {
		MODE_SHA256 = 1'b0,
		MODE_SHA224 = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} core_state_t;

	// Block job handed from the front part to the compression core.
	typedef struct packed {
		logic [511:0] block;
		logic         open;   // reload chaining words before compressing
		logic         mode;   // mode latched for this message
		logic         emit;   // emit digest after this block
	} job_t;

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [255:0] init_value(input logic mode);
		if (mode == MODE_SHA224) begin
			return {32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
				32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
		end
		return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

/* sv/sha2_if.sv */
// Valid/ready channel interfaces for the SHA-256/224 engine.
// Depends on nothing.
interface sha2_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] message_byte;
	modport source (output valid, output command, output message_byte, input ready);
	modport sink (input valid, input command, input message_byte, output ready);
endinterface

interface sha2_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

/* sv/sha2_front.sv */
// Front part: packs bytes into blocks, pads on finish, pushes block jobs.
// Depends on sha2_pkg and sha2_if.
module sha2_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             digest_mode,
	sha2_in_if.sink          in_ch,
	output logic             job_valid,
	output sha2_pkg::job_t   job,
	input  logic             job_ready
);

	logic [511:0] block_q;
	logic [60:0]  total_q;
	logic         open_q;     // message is open
	logic         fresh_q;    // next job must reload the chaining words
	logic         mode_q;
	logic         pad2_q;     // second padding block still to push
	logic         jv_q;
	sha2_pkg::job_t job_q;

	logic [5:0]   pos;
	logic [511:0] merged;
	logic [511:0] padded;
	logic [63:0]  bits;
	logic         cur_mode;
	logic         can_push;

	assign pos      = total_q[5:0];
	assign bits     = {total_q, 3'b000};
	assign cur_mode = open_q ? mode_q : digest_mode;
	assign can_push = !jv_q || job_ready;
	assign in_ch.ready = can_push && !pad2_q;
	assign job_valid = jv_q;
	assign job       = job_q;

	// Merge the byte (or the 0x80 marker) at pos and, on a finish, clear the bytes after it
	always_comb begin
		logic [7:0] b;
		b = (in_ch.command == sha2_pkg::CMD_FINISH) ? 8'h80 : in_ch.message_byte;
		merged = block_q;
		for (int i = 0; i < 64; i++) begin
			if (i[5:0] == pos) begin
				merged[511 - 8*i -: 8] = b;
			end else if (i[5:0] > pos && in_ch.command == sha2_pkg::CMD_FINISH) begin
				merged[511 - 8*i -: 8] = 8'h00;
			end
		end
		padded = {merged[511:64], bits};
	end

	// Accept transactions and push block jobs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			open_q  <= 1'b0;
			fresh_q <= 1'b0;
			mode_q  <= 1'b0;
			pad2_q  <= 1'b0;
			jv_q    <= 1'b0;
		end else begin
			if (jv_q && job_ready) jv_q <= 1'b0;
			if (pad2_q && can_push) begin
				jv_q       <= 1'b1;
				job_q      <= '{block: {448'd0, bits}, open: 1'b0, mode: mode_q, emit: 1'b1};
				pad2_q     <= 1'b0;
				open_q     <= 1'b0;
				total_q    <= '0;
			end else if (in_ch.valid && in_ch.ready) begin
				if (!open_q) begin
					mode_q  <= digest_mode;
					open_q  <= 1'b1;
				end
				if (in_ch.command == sha2_pkg::CMD_ABSORB) begin
					block_q <= merged;
					total_q <= total_q + 61'd1;
					if (!open_q) fresh_q <= 1'b1;
					if (pos == 6'd63) begin
						jv_q    <= 1'b1;
						job_q   <= '{block: merged, open: fresh_q || !open_q,
							mode: cur_mode, emit: 1'b0};
						fresh_q <= 1'b0;
					end
				end else begin
					jv_q    <= 1'b1;
					fresh_q <= 1'b0;
					if (pos > 6'd55) begin
						job_q  <= '{block: merged, open: fresh_q || !open_q,
							mode: cur_mode, emit: 1'b0};
						pad2_q <= 1'b1;
					end else begin
						job_q   <= '{block: padded, open: fresh_q || !open_q,
							mode: cur_mode, emit: 1'b1};
						open_q  <= 1'b0;
						total_q <= '0;
					end
				end
			end
		end
	end

endmodule

/* sv/sha2_fifo.sv */
// Short job queue between front and core, so each side stalls on its own.
// Depends on sha2_pkg.
module sha2_fifo #(
	parameter int Depth = sha2_pkg::FifoDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  sha2_pkg::job_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output sha2_pkg::job_t rd_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	sha2_pkg::job_t      mem_q [Depth];
	logic [AW-1:0]       wp_q, rp_q;
	logic [AW:0]         cnt_q;
	logic                push, pop;

	assign wr_ready = (cnt_q != AW'(0) + (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
			if (pop)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

/* sv/sha2_core.sv */
// Back part: 64-round compression, one round a cycle, and digest output.
// Depends on sha2_pkg and sha2_if.
module sha2_core #(
	parameter int RoundCount = sha2_pkg::RoundCount
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  sha2_pkg::job_t job,
	sha2_out_if.source     out_ch
);

	sha2_pkg::core_state_t state_q, state_d;
	logic [255:0] h_q;
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [5:0]   rnd_q;
	logic         emit_q, mode_q;
	logic [2:0]   idx_q;
	logic [31:0]  t1, t2, s0, s1, w_new;

	// Round datapath
	always_comb begin
		t1 = v_q[7] + (sha2_pkg::rotr(v_q[4], 6) ^ sha2_pkg::rotr(v_q[4], 11)
			^ sha2_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha2_pkg::round_k(rnd_q) + w_q[0];
		t2 = (sha2_pkg::rotr(v_q[0], 2) ^ sha2_pkg::rotr(v_q[0], 13)
			^ sha2_pkg::rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		s0 = sha2_pkg::rotr(w_q[1], 7) ^ sha2_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha2_pkg::rotr(w_q[14], 17) ^ sha2_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
	end

	// Next state and handshakes
	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		case (state_q)
			sha2_pkg::ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) state_d = sha2_pkg::ST_ROUND;
			end
			sha2_pkg::ST_ROUND: begin
				if (rnd_q == 6'(RoundCount - 1)) state_d = sha2_pkg::ST_ADD;
			end
			sha2_pkg::ST_ADD: begin
				state_d = emit_q ? sha2_pkg::ST_EMIT : sha2_pkg::ST_IDLE;
			end
			sha2_pkg::ST_EMIT: begin
				if (out_ch.ready && out_ch.last_word) state_d = sha2_pkg::ST_IDLE;
			end
			default: state_d = sha2_pkg::ST_IDLE;
		endcase
	end

	assign out_ch.valid       = (state_q == sha2_pkg::ST_EMIT);
	assign out_ch.digest_word = h_q[255 - 32*idx_q -: 32];
	assign out_ch.word_index  = idx_q;
	assign out_ch.last_word   = (idx_q == (mode_q ? 3'd6 : 3'd7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sha2_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Load job, run rounds, add and step through the digest words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q   <= sha2_pkg::init_value(sha2_pkg::MODE_SHA256);
			rnd_q <= '0;
			idx_q <= '0;
			emit_q <= 1'b0;
			mode_q <= 1'b0;
		end else begin
			case (state_q)
				sha2_pkg::ST_IDLE: begin
					if (job_valid) begin
						logic [255:0] hs;
						hs = job.open ? sha2_pkg::init_value(job.mode) : h_q;
						h_q    <= hs;
						emit_q <= job.emit;
						mode_q <= job.mode;
						rnd_q  <= '0;
						idx_q  <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= hs[255 - 32*i -: 32];
						for (int i = 0; i < 16; i++) w_q[i] <= job.block[511 - 32*i -: 32];
					end
				end
				sha2_pkg::ST_ROUND: begin
					v_q[0] <= t1 + t2;
					v_q[1] <= v_q[0];
					v_q[2] <= v_q[1];
					v_q[3] <= v_q[2];
					v_q[4] <= v_q[3] + t1;
					v_q[5] <= v_q[4];
					v_q[6] <= v_q[5];
					v_q[7] <= v_q[6];
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= w_new;
					rnd_q <= rnd_q + 6'd1;
				end
				sha2_pkg::ST_ADD: begin
					for (int i = 0; i < 8; i++)
						h_q[255 - 32*i -: 32] <= h_q[255 - 32*i -: 32] + v_q[i];
				end
				sha2_pkg::ST_EMIT: begin
					if (out_ch.ready) idx_q <= idx_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

endmodule

/* sv/sha256_sha224_hash_engine_top.sv */
// Top level of the SHA-256/224 hash engine: front, job queue and core.
// Depends on sha2_pkg, sha2_if, sha2_front, sha2_fifo and sha2_core.
//
//  channel   | dir | payload
//  in_ch     | in  | command, message_byte
//  out_ch    | out | digest_word, word_index, last_word
//  cfg       | in  | cfg_we, cfg_wdata (digest_mode)
//
// Every 64th byte taken in hands a block to the core.
// The core takes a block through load, 64 rounds and add on its one round unit, and takes no new block before then.
// A finish adds one or two padding blocks, then 7 or 8 digest words.
// Reset clears all control state at once; no clearing pass.
// Input stalls while the job queue is full, and while a finish waits to
// push its second padding block.
module sha256_sha224_hash_engine_top #(
	parameter int RoundCount = sha2_pkg::RoundCount,
	parameter int FifoDepth  = sha2_pkg::FifoDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	sha2_in_if.sink    in_ch,
	sha2_out_if.source out_ch
);

	logic           mode_q;
	logic           fj_valid, fj_ready, cj_valid, cj_ready;
	sha2_pkg::job_t fj, cj;

	// Hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b0;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	sha2_front u_front (
		.clk, .arst_n, .digest_mode(mode_q), .in_ch,
		.job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
	);

	sha2_fifo #(.Depth(FifoDepth)) u_fifo (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
		.rd_valid(cj_valid), .rd_ready(cj_ready), .rd_data(cj)
	);

	sha2_core #(.RoundCount(RoundCount)) u_core (
		.clk, .arst_n, .job_valid(cj_valid), .job_ready(cj_ready), .job(cj), .out_ch
	);

`ifndef SYNTHESIS
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && !out_ch.last_word |=>
		out_ch.word_index == $past(out_ch.word_index) + 3'd1) else $error("word order");
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> out_ch.word_index == 3'd0) else $error("first word");
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.last_word |-> out_ch.word_index == 3'd6
		|| out_ch.word_index == 3'd7) else $error("last word");
`endif

endmodule
